@@ sv/eased_quadratic_bezier_follower_defines.svh @@
// ----------------------------------------------------------------------------
// Eased quadratic Bezier follower assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EASED_QUADRATIC_BEZIER_FOLLOWER_DEFINES_SVH
`define EASED_QUADRATIC_BEZIER_FOLLOWER_DEFINES_SVH

// Condition that holds at every edge
`define EQBF_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence in the same cycle
`define EQBF_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence in the next cycle
`define EQBF_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/eqbf_pkg.sv @@
// ----------------------------------------------------------------------------
// Eased quadratic Bezier follower package
// Sequencer states, constants, register indexes and the Q30 root table.
// ----------------------------------------------------------------------------
package eqbf_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_C, S_DIV, S_DIVEND, S_SS, S_SQ, S_CUBE, S_SEND, S_F,
    S_NORM, S_LOGSQ, S_LOGCHK, S_LG, S_Y, S_POW, S_POWUPD, S_IPOW,
    S_LMUL, S_LADD, S_FIN
  } state_t;

  typedef enum logic [1:0] {PH_C, PH_S1, PH_S2} phase_t;

  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CONTROL_POINT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_POINT       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRAVEL_DURATION = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EASE_IN_TIME    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EASE_OUT_TIME   = 3'd4;

  localparam logic [16:0] ONE_Q16       = 17'd65536;
  localparam logic [15:0] EASE_IN_START = 16'd6554;
  localparam logic [15:0] HALF_Q16      = 16'd32768;
  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;

  typedef logic [30:0] root_tab_t [16];

  // Floor square root of a 64-bit value
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Factors 2^(-2^-(k+1)) in Q30, each the floor root of the one before
  function automatic root_tab_t build_roots();
    root_tab_t tab;
    logic [63:0] rt;
    rt = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      rt = isqrt64(rt << 30);
      tab[k] = rt[30:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_Q30 = build_roots();

endpackage

@@ sv/eqbf_tick_if.sv @@
// ----------------------------------------------------------------------------
// Eased quadratic Bezier follower channels
// Tick input channel and curve point output channel, valid/ready.
// ----------------------------------------------------------------------------
interface eqbf_tick_if #(
  parameter int COORD_BITS = 16,
  parameter int TIME_BITS  = 32
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         time_now;
  logic signed [COORD_BITS-1:0] current_x;
  logic signed [COORD_BITS-1:0] current_y;
  logic signed [COORD_BITS-1:0] current_z;

  modport source(output valid, time_now, current_x, current_y, current_z, input ready);
  modport sink(input valid, time_now, current_x, current_y, current_z, output ready);
endinterface

interface eqbf_point_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] curve_x;
  logic signed [COORD_BITS-1:0] curve_y;
  logic signed [COORD_BITS-1:0] curve_z;
  logic                         done_flag;

  modport source(output valid, curve_x, curve_y, curve_z, done_flag, input ready);
  modport sink(input valid, curve_x, curve_y, curve_z, done_flag, output ready);
endinterface

@@ sv/eased_quadratic_bezier_follower.sv @@
// ----------------------------------------------------------------------------
// Eased quadratic Bezier follower
// Moves an object along a 3D quadratic Bezier with eased timing, one tick
// item in, one curve point item out.
// ----------------------------------------------------------------------------
// Usage:
//   tick  : time_now (Q16.16) and the object position (Q8.8). The first tick
//           after reset latches the start time and start point.
//   point : curve_x/y/z (Q8.8) and the sticky done_flag.
//   cfg   : write enable, register index and data; write only while idle.
// Flow: one tick at a time through a sequencer around one shared 34x34
//   multiplier and a radix-2 divider. A tick runs up to three 16-step
//   divisions and nine lerp steps; when a fractional power is needed it also
//   runs 16 squarings for the logarithm and 16 root products for the power
//   on the multiplier. tick.ready is high only while the sequencer is idle.
// Reset: synchronous; clears the start and finished state and loads the
//   register defaults (duration 1 s, ease edges 0.5 s, points at origin).
// Stall: the result waits in an output register; the next tick is taken and
//   worked on meanwhile, and it holds in its last step until point is free.
// ----------------------------------------------------------------------------
`include "eased_quadratic_bezier_follower_defines.svh"

module eased_quadratic_bezier_follower
  import eqbf_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic clk,
  input  logic rst,
  eqbf_tick_if.sink    tick,
  eqbf_point_if.source point,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((3*COORD_BITS > TIME_BITS) ? 3*COORD_BITS : TIME_BITS)-1:0] cfg_data
);

  localparam int CB = COORD_BITS;
  localparam int TB = TIME_BITS;
  localparam int CW = 3 * CB;

  // Packed points keep only the low 64 register bits
  function automatic logic [CW-1:0] keep_mask();
    logic [CW-1:0] m;
    for (int b = 0; b < CW; b++) m[b] = (b < 64);
    return m;
  endfunction
  localparam logic [CW-1:0] KEEP = keep_mask();

  // Configuration registers
  logic [CW-1:0] cp_reg, end_reg;
  logic [TB-1:0] dur, ease_in, ease_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_reg   <= '0;
      end_reg  <= '0;
      dur      <= TB'(ONE_Q16);
      ease_in  <= TB'(HALF_Q16);
      ease_out <= TB'(HALF_Q16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONTROL_POINT:   cp_reg   <= cfg_data[CW-1:0] & KEEP;
        REG_END_POINT:       end_reg  <= cfg_data[CW-1:0] & KEEP;
        REG_TRAVEL_DURATION: dur      <= cfg_data[TB-1:0];
        REG_EASE_IN_TIME:    ease_in  <= cfg_data[TB-1:0];
        REG_EASE_OUT_TIME:   ease_out <= cfg_data[TB-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  phase_t ph;

  // Tracking state
  logic                 started, finished;
  logic [TB-1:0]        start_time, elapsed;
  logic signed [CB-1:0] st_c [3];

  // Working registers
  logic [16:0]          c, s1, f, t, ival;
  logic [TB-1:0]        rem, dvs;
  logic [15:0]          quot, xn, fr, rbits;
  logic [3:0]           cnt, nsh;
  logic [31:0]          x;
  logic [4:0]           q;
  logic [30:0]          res;
  logic [1:0]           lk, lm;
  logic                 neg;
  logic signed [CB-1:0] la, lb;
  logic signed [CB-1:0] pt [3];
  logic [67:0]          prod;
  logic [33:0]          mul_a, mul_b;

  // Output register
  logic                 out_valid, out_done;
  logic signed [CB-1:0] out_x, out_y, out_z;

  // Unpacked points
  logic signed [CB-1:0] cp_c [3], en_c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cp_c[k] = cp_reg[k*CB +: CB];
      en_c[k] = end_reg[k*CB +: CB];
    end
  end

  // Smoothstep setup: spans and the early decisions
  logic [TB-1:0] e0, e1, an, ad;
  logic [TB:0]   n, d, nneg, dneg;
  logic          ss_step, ss_zero, ss_div;
  logic [16:0]   ss_t;
  always_comb begin
    e0   = (ph == PH_S1) ? TB'(EASE_IN_START) : ease_out;
    e1   = (ph == PH_S1) ? ease_in : dur;
    n    = {1'b0, elapsed} - {1'b0, e0};
    d    = {1'b0, e1} - {1'b0, e0};
    nneg = -n;
    dneg = -d;
    an   = n[TB] ? nneg[TB-1:0] : n[TB-1:0];
    ad   = d[TB] ? dneg[TB-1:0] : d[TB-1:0];
    ss_step = (d == '0);
    ss_zero = (n == '0) || (n[TB] != d[TB]);
    ss_div  = !ss_step && !ss_zero && (an < ad);
    if (ss_step)       ss_t = n[TB] ? 17'd0 : ONE_Q16;
    else if (ss_zero)  ss_t = 17'd0;
    else               ss_t = ONE_Q16;
  end

  // Divider step
  logic [TB:0] r2, r2sub;
  logic        ge;
  always_comb begin
    r2    = {rem, 1'b0};
    r2sub = r2 - {1'b0, dvs};
    ge    = (r2 >= {1'b0, dvs});
  end

  // Lerp operands and step
  logic signed [CB-1:0] lop_a, lop_b;
  logic signed [CB:0]   diff;
  logic [CB:0]          mag;
  logic [CB+17:0]       up;
  logic [CB+1:0]        stp, lsum;
  always_comb begin
    unique case (lm)
      2'd0:    begin lop_a = st_c[lk]; lop_b = cp_c[lk]; end
      2'd1:    begin lop_a = cp_c[lk]; lop_b = en_c[lk]; end
      default: begin lop_a = la;       lop_b = lb;       end
    endcase
    diff = (CB+1)'(lop_b) - (CB+1)'(lop_a);
    mag  = diff[CB] ? (CB+1)'(-diff) : diff;
    up   = prod[CB+17:0] + (CB+18)'(65535);
    stp  = neg ? up[CB+17:16] : prod[CB+17:16];
    lsum = neg ? (CB+2)'(lop_a) - stp : (CB+2)'(lop_a) + stp;
  end

  // Other datapath terms
  logic [17:0] cube_k;
  logic [16:0] s_val;
  logic [31:0] xs;
  logic [20:0] lg;
  logic [30:0] pshift;
  logic [4:0]  psh;
  logic        at_end, done_now, fin_go;
  always_comb begin
    cube_k   = 18'd196608 - {t, 1'b0};
    s_val    = prod[48:32];
    xs       = prod[61:30];
    lg       = {5'd1 + 5'(nsh), 16'h0000} - 21'(fr);
    psh      = 5'd14 + q;
    pshift   = res >> psh;
    at_end   = (pt[0] == en_c[0]) && (pt[1] == en_c[1]) && (pt[2] == en_c[2]);
    done_now = finished || at_end || (elapsed >= dur);
    fin_go   = !out_valid || point.ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (tick.valid) state_next = S_C;
      S_C:      state_next = (elapsed >= dur) ? S_SS : S_DIV;
      S_DIV:    if (cnt == 4'd15) state_next = S_DIVEND;
      S_DIVEND: state_next = (ph == PH_C) ? S_SS : S_SQ;
      S_SS:     state_next = ss_div ? S_DIV : S_SQ;
      S_SQ:     state_next = S_CUBE;
      S_CUBE:   state_next = S_SEND;
      S_SEND:   state_next = (ph == PH_S1) ? S_SS : S_F;
      S_F: begin
        if (prod[32:16] == 17'd0 || c == 17'd0 || c[16]) state_next = S_LMUL;
        else state_next = S_NORM;
      end
      S_NORM:   if (xn[15]) state_next = S_LOGSQ;
      S_LOGSQ:  state_next = S_LOGCHK;
      S_LOGCHK: state_next = (cnt == 4'd15) ? S_LG : S_LOGSQ;
      S_LG:     state_next = S_Y;
      S_Y:      state_next = S_POW;
      S_POW:    state_next = S_POWUPD;
      S_POWUPD: state_next = (cnt == 4'd15) ? S_IPOW : S_POW;
      S_IPOW:   state_next = S_LMUL;
      S_LMUL:   state_next = S_LADD;
      S_LADD:   state_next = (lm == 2'd2 && lk == 2'd2) ? S_FIN : S_LMUL;
      S_FIN:    if (fin_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and multiplier operands
  always_comb begin
    tick.ready = (state == S_IDLE);
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ:     begin mul_a = 34'(t);            mul_b = 34'(t);               end
      S_CUBE:   begin mul_a = prod[33:0];        mul_b = 34'(cube_k);          end
      S_SEND:   begin mul_a = 34'(s1);           mul_b = 34'(ONE_Q16 - s_val); end
      S_LOGSQ:  begin mul_a = 34'(x);            mul_b = 34'(x);               end
      S_LG:     begin mul_a = 34'(lg);           mul_b = 34'(f);               end
      S_POW: begin
        mul_a = 34'(res);
        mul_b = rbits[15] ? 34'(ROOT_Q30[cnt]) : 34'(ONE_Q30);
      end
      S_LMUL:   begin mul_a = 34'(mag);          mul_b = 34'(ival);            end
      default: ;
    endcase
  end

  // Shared multiplier
  always_ff @(posedge clk) prod <= mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Control and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      finished   <= 1'b0;
      out_valid  <= 1'b0;
      start_time <= '0;
      st_c[0]    <= '0;
      st_c[1]    <= '0;
      st_c[2]    <= '0;
    end else begin
      if (state == S_IDLE && tick.valid && !started) begin
        started    <= 1'b1;
        start_time <= tick.time_now;
        st_c[0]    <= tick.current_x;
        st_c[1]    <= tick.current_y;
        st_c[2]    <= tick.current_z;
      end
      if (state == S_FIN && fin_go) begin
        finished  <= done_now;
        out_valid <= 1'b1;
      end else if (point.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        elapsed <= started ? tick.time_now - start_time : '0;
        ph      <= PH_C;
      end
      S_C: begin
        cnt  <= '0;
        quot <= '0;
        if (elapsed >= dur) begin
          c  <= ONE_Q16;
          ph <= PH_S1;
        end else begin
          rem <= elapsed;
          dvs <= dur;
        end
      end
      S_DIV: begin
        rem  <= ge ? r2sub[TB-1:0] : r2[TB-1:0];
        quot <= {quot[14:0], ge};
        cnt  <= cnt + 4'd1;
      end
      S_DIVEND: begin
        if (ph == PH_C) begin
          c  <= {1'b0, quot};
          ph <= PH_S1;
        end else begin
          t <= {1'b0, quot};
        end
      end
      S_SS: begin
        t    <= ss_t;
        rem  <= an;
        dvs  <= ad;
        cnt  <= '0;
        quot <= '0;
      end
      S_SEND: begin
        if (ph == PH_S1) begin
          s1 <= s_val;
          ph <= PH_S2;
        end
      end
      S_F: begin
        f    <= prod[32:16];
        ival <= c;
        xn   <= c[15:0];
        nsh  <= '0;
        lk   <= '0;
        lm   <= '0;
      end
      S_NORM: begin
        if (xn[15]) begin
          x   <= {1'b0, xn, 15'h0000};
          fr  <= '0;
          cnt <= '0;
        end else begin
          xn  <= {xn[14:0], 1'b0};
          nsh <= nsh + 4'd1;
        end
      end
      S_LOGCHK: begin
        x   <= xs[31] ? {1'b0, xs[31:1]} : xs;
        fr  <= {fr[14:0], xs[31]};
        cnt <= cnt + 4'd1;
      end
      S_Y: begin
        q     <= prod[36:32];
        rbits <= prod[31:16];
        res   <= ONE_Q30;
        cnt   <= '0;
      end
      S_POWUPD: begin
        res   <= prod[60:30];
        rbits <= {rbits[14:0], 1'b0};
        cnt   <= cnt + 4'd1;
      end
      S_IPOW: begin
        ival <= (pshift > 31'(ONE_Q16)) ? ONE_Q16 : pshift[16:0];
        lk   <= '0;
        lm   <= '0;
      end
      S_LMUL: neg <= diff[CB];
      S_LADD: begin
        unique case (lm)
          2'd0:    la      <= lsum[CB-1:0];
          2'd1:    lb      <= lsum[CB-1:0];
          default: pt[lk]  <= lsum[CB-1:0];
        endcase
        if (lm == 2'd2) begin
          lm <= '0;
          lk <= lk + 2'd1;
        end else begin
          lm <= lm + 2'd1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_x    <= pt[0];
          out_y    <= pt[1];
          out_z    <= pt[2];
          out_done <= done_now;
        end
      end
      default: ;
    endcase
  end

  assign point.valid     = out_valid;
  assign point.curve_x   = out_x;
  assign point.curve_y   = out_y;
  assign point.curve_z   = out_z;
  assign point.done_flag = out_done;

  // Checks
  `EQBF_IMPLY_NEXT(a_accept_busy, tick.valid && tick.ready, state != S_IDLE, "tick taken but sequencer idle")
  `EQBF_IMPLY(a_ival_range, state == S_LMUL, ival <= ONE_Q16, "curve parameter above one")
  `EQBF_CHECK(a_done_sticky, !$fell(finished), "finished flag dropped")
  `EQBF_IMPLY(a_out_done, point.valid, point.done_flag == finished, "done flag out of step")

endmodule

@@ dv/tb_eased_quadratic_bezier_follower.sv @@
// ----------------------------------------------------------------------------
// Eased quadratic Bezier follower testbench
// Drives tick items through a directed table and then randomized phases of
// configuration, and checks every curve point item against a table value or
// a local predictor of the eased Bezier arithmetic; both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_eased_quadratic_bezier_follower;
  import eqbf_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam int RAND_PHASES = 15;
  localparam int PHASE_TICKS = 100;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               done;
  } point_t;

  typedef struct {
    logic                      is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [47:0]               data;
    logic [31:0]               t;
    logic signed [15:0]        x;
    logic signed [15:0]        y;
    logic signed [15:0]        z;
    logic                      typed;
    point_t                    want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [47:0]               cfg_data = '0;
  logic quiet = 1'b0;

  eqbf_tick_if #(.COORD_BITS(16), .TIME_BITS(32)) tk();
  eqbf_point_if #(.COORD_BITS(16)) pt();

  eased_quadratic_bezier_follower #(.COORD_BITS(16), .TIME_BITS(32)) u_dut (
    .clk(clk), .rst(rst), .tick(tk), .point(pt),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of registers and tick state
  logic [47:0] m_ctrl, m_dest;
  logic [31:0] m_dur, m_ein, m_eout;
  logic        m_started, m_finished;
  logic [31:0] m_t0;
  logic signed [15:0] m_sx, m_sy, m_sz;

  point_t point_q[$];
  row_t   rows[$];
  int     err_count = 0;
  int     ticks_sent = 0;
  int     points_seen = 0;

  always #10 clk = ~clk;

  // Limit on the whole run
  initial begin
    #40_000_000;
    $display("eased_quadratic_bezier_follower test failed");
    $finish;
  end

  function automatic logic [63:0] floor_root(input logic [63:0] val);
    logic [63:0] v, r, b;
    v = val;
    r = '0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] smoothstep_q16(input logic [31:0] xv, e0, e1);
    longint n, d;
    logic [63:0] t, an, ad;
    n = longint'({32'd0, xv}) - longint'({32'd0, e0});
    d = longint'({32'd0, e1}) - longint'({32'd0, e0});
    if (d == 0) begin
      t = (n >= 0) ? 64'd65536 : 64'd0;
    end else if (n == 0 || ((n < 0) != (d < 0))) begin
      t = 0;
    end else begin
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      t = (an >= ad) ? 64'd65536 : (an << 16) / ad;
    end
    return (t * t * (64'd196608 - 2 * t)) >> 32;
  endfunction

  // c^f through a truncated log2 and a product of Q30 roots
  function automatic logic [63:0] eased_power(input logic [63:0] c, f);
    int p;
    logic [63:0] xs, fr, lg, y, q, r, res, root;
    p = 15;
    while (!c[p]) p--;
    xs = c << (30 - p);
    fr = 0;
    for (int k = 0; k < 16; k++) begin
      xs = (xs * xs) >> 30;
      fr = fr << 1;
      if (xs >= (64'd2 << 30)) begin
        xs = xs >> 1;
        fr = fr | 1;
      end
    end
    lg = (64'(16 - p) << 16) - fr;
    y = (lg * f) >> 16;
    q = y >> 16;
    r = y & 64'hFFFF;
    res = 64'd1 << 30;
    root = 64'd1 << 29;
    for (int j = 15; j >= 0; j--) begin
      root = floor_root(root << 30);
      if (r[j]) res = (res * root) >> 30;
    end
    return res >> (14 + q);
  endfunction

  function automatic longint blend(input longint a, b, input logic [63:0] i);
    longint prod, stp;
    prod = (b - a) * longint'(i);
    if (prod >= 0) stp = prod >>> 16;
    else stp = -((-prod + 65535) >>> 16);
    return a + stp;
  endfunction

  function automatic longint coord_of(input logic [47:0] r, input int k);
    logic signed [15:0] v;
    v = r[16*k +: 16];
    return longint'(v);
  endfunction

  // Advance the follower state by one tick and give the curve point
  function automatic point_t follow_tick(input logic [31:0] now,
                                         input logic signed [15:0] x, y, z);
    logic [31:0] el;
    logic [63:0] c, f, i;
    longint s[3], e[3], p[3], cp;
    point_t res;
    if (!m_started) begin
      m_started = 1'b1;
      m_t0 = now;
      m_sx = x;
      m_sy = y;
      m_sz = z;
    end
    el = now - m_t0;
    if (el >= m_dur) c = 65536;
    else c = ({32'd0, el} << 16) / m_dur;
    f = (smoothstep_q16(el, 32'd6554, m_ein) *
         (64'd65536 - smoothstep_q16(el, m_eout, m_dur))) >> 16;
    if (f == 0 || c == 0 || c >= 65536) i = c;
    else i = eased_power(c, f);
    if (i > 65536) i = 65536;
    s[0] = m_sx; s[1] = m_sy; s[2] = m_sz;
    for (int k = 0; k < 3; k++) begin
      cp = coord_of(m_ctrl, k);
      e[k] = coord_of(m_dest, k);
      p[k] = blend(blend(s[k], cp, i), blend(cp, e[k], i), i);
    end
    if ((p[0] == e[0] && p[1] == e[1] && p[2] == e[2]) || el >= m_dur)
      m_finished = 1'b1;
    res.x = p[0][15:0];
    res.y = p[1][15:0];
    res.z = p[2][15:0];
    res.done = m_finished;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Check each point item against the oldest expectation
  always @(posedge clk) begin
    point_t w;
    if (!rst && pt.valid && pt.ready) begin
      points_seen++;
      if (point_q.size() == 0) begin
        report_mismatch("unexpected point item", 1, 0);
      end else begin
        w = point_q.pop_front();
        if (pt.curve_x !== w.x) report_mismatch("curve_x", pt.curve_x, w.x);
        if (pt.curve_y !== w.y) report_mismatch("curve_y", pt.curve_y, w.y);
        if (pt.curve_z !== w.z) report_mismatch("curve_z", pt.curve_z, w.z);
        if (pt.done_flag !== w.done) report_mismatch("done_flag", pt.done_flag, w.done);
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    pt.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 33);
  end

  task automatic send_tick(input logic [31:0] t, input logic signed [15:0] x, y, z,
                           input logic typed, input point_t want);
    point_t got;
    if (!quiet && $urandom_range(0, 99) < 33) begin
      tk.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    tk.valid <= 1'b1;
    tk.time_now <= t;
    tk.current_x <= x;
    tk.current_y <= y;
    tk.current_z <= z;
    @(posedge clk);
    while (!tk.ready) @(posedge clk);
    got = follow_tick(t, x, y, z);
    point_q = {point_q, (typed ? want : got)};
    ticks_sent++;
  endtask

  task automatic drain_points();
    tk.valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [47:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CONTROL_POINT:   m_ctrl = data;
      REG_END_POINT:       m_dest = data;
      REG_TRAVEL_DURATION: m_dur = data[31:0];
      REG_EASE_IN_TIME:    m_ein = data[31:0];
      REG_EASE_OUT_TIME:   m_eout = data[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [47:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    rows = {rows, r};
  endtask

  task automatic add_tick(input logic [31:0] t, input logic signed [15:0] x, y, z,
                          input logic typed, input point_t want);
    row_t r;
    r = '{default: '0};
    r.t = t;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endtask

  function automatic logic [31:0] pick_span(input logic [31:0] lim);
    logic [63:0] v;
    v = $urandom_range(0, 99) < 10 ? $urandom : ({$urandom} % ({32'd0, lim} + 1));
    return v[31:0];
  endfunction

  initial begin
    point_t none, at_dest;
    logic [47:0] dest;
    logic [31:0] dur, ein, eout, el;
    none = '0;

    tk.valid = 1'b0;
    tk.time_now = '0;
    tk.current_x = '0;
    tk.current_y = '0;
    tk.current_z = '0;

    m_ctrl = '0; m_dest = '0;
    m_dur = 32'd65536; m_ein = 32'd32768; m_eout = 32'd32768;
    m_started = 1'b0; m_finished = 1'b0;
    m_t0 = '0; m_sx = '0; m_sy = '0; m_sz = '0;

    // Directed table: start latch, saturation, degenerate and reversed edges
    dest = {16'sd32767, 16'sd200, -16'sd100};
    at_dest = '{x: -16'sd100, y: 16'sd200, z: 16'sd32767, done: 1'b1};
    add_tick(32'd1000, -16'sd32768, 16'sd32767, 16'sd100, 1'b1,
             '{x: -16'sd32768, y: 16'sd32767, z: 16'sd100, done: 1'b0});
    add_tick(32'd1000 + 32'd65536, 16'sd5, 16'sd5, 16'sd5, 1'b1,
             '{x: 16'sd0, y: 16'sd0, z: 16'sd0, done: 1'b1});
    add_cfg(REG_CONTROL_POINT, {16'h1234, 16'h8000, 16'h7FFF});
    add_cfg(REG_END_POINT, dest);
    add_tick(32'd1000 + 32'd327680, 16'sd0, 16'sd0, 16'sd0, 1'b1, at_dest);
    add_tick(32'd1000 + 32'd20000, 16'sd1, 16'sd2, 16'sd3, 1'b0, none);
    add_tick(32'd1000 + 32'd40000, -16'sd1, -16'sd2, -16'sd3, 1'b0, none);
    add_cfg(REG_TRAVEL_DURATION, 48'd0);
    add_tick(32'd1000, 16'sd0, 16'sd0, 16'sd0, 1'b1, at_dest);
    add_cfg(REG_TRAVEL_DURATION, 48'hFFFF_FFFF);
    add_cfg(REG_EASE_IN_TIME, 48'd6554);
    add_cfg(REG_EASE_OUT_TIME, 48'hFFFF_FFFF);
    add_tick(32'd1000 + 32'd6553, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
    add_tick(32'd1000 + 32'd6554, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
    add_tick(32'd1000 + 32'd100000, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
    add_cfg(REG_EASE_IN_TIME, 48'd0);
    add_cfg(REG_EASE_OUT_TIME, 48'd0);
    add_tick(32'd1000 + 32'd3000, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
    add_tick(32'd1000 + 32'd900000, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
    add_tick(32'd999, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
    add_cfg(REG_SPARE_LO, 48'hFFFF_FFFF_FFFF);
    add_cfg(REG_SPARE_HI, 48'hFFFF_FFFF_FFFF);
    add_cfg(REG_EASE_IN_TIME, 48'hFFFF_FFFF);
    add_cfg(REG_TRAVEL_DURATION, 48'd131072);
    add_tick(32'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);
    add_tick(32'hFFFF_FFFF, -16'sd1, -16'sd1, -16'sd1, 1'b0, none);
    add_tick(32'd1000 + 32'd70000, 16'sd0, 16'sd0, 16'sd0, 1'b0, none);

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (rows[n]) begin
      if (rows[n].is_cfg) begin
        drain_points();
        write_reg(rows[n].idx, rows[n].data);
      end else begin
        send_tick(rows[n].t, rows[n].x, rows[n].y, rows[n].z, rows[n].typed, rows[n].want);
      end
    end

    // Random phases: new registers, then ticks over the travel window
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_points();
      quiet <= (ph == 4 || ph == 5);
      case ($urandom_range(0, 7))
        0: dur = 32'd0;
        1: dur = $urandom_range(1, 20000);
        2: dur = $urandom;
        3: dur = 32'hFFFF_FFFF;
        default: dur = 32'd65536 * $urandom_range(1, 6) + $urandom_range(0, 65535);
      endcase
      ein = 32'd6554 + pick_span(dur >> 1);
      eout = ein + pick_span(dur >> 1);
      case ($urandom_range(0, 5))
        0: write_reg(REG_CONTROL_POINT, 48'h7FFF_7FFF_7FFF);
        1: write_reg(REG_CONTROL_POINT, 48'h8000_8000_8000);
        default: write_reg(REG_CONTROL_POINT, 48'({$urandom, $urandom}));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_END_POINT, 48'h8000_8000_8000);
        1: write_reg(REG_END_POINT, 48'h7FFF_7FFF_7FFF);
        default: write_reg(REG_END_POINT, 48'({$urandom, $urandom}));
      endcase
      write_reg(REG_TRAVEL_DURATION, {16'd0, dur});
      write_reg(REG_EASE_IN_TIME, 48'({$urandom, ein}));
      write_reg(REG_EASE_OUT_TIME, {16'd0, eout});
      for (int n = 0; n < PHASE_TICKS; n++) begin
        el = pick_span((dur > 32'hE000_0000) ? 32'hFFFF_FFFF : dur + (dur >> 3));
        send_tick(m_t0 + el, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, none);
      end
    end

    // Let every point arrive, then a margin
    drain_points();
    repeat (200) @(posedge clk);
    $display("Sent %0d tick items over %0d random register settings; %0d points checked.",
             ticks_sent, RAND_PHASES, points_seen);
    if (err_count == 0 && point_q.size() == 0) begin
      $display("eased_quadratic_bezier_follower test passed");
    end else begin
      $display("eased_quadratic_bezier_follower test failed");
    end
    $finish;
  end

endmodule
